// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by the file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define AM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define AM_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sset_pkg.sv =====
// shared codes and controller/datapath bundles of the sorted key set
// no dependencies
package sset_pkg;

    // request codes
    localparam logic [1:0] OP_MEMBER = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int KEY_W = 32;
    localparam int OCC_W = 7;

    // controller to datapath
    typedef struct packed {
        logic       start;       // load request, rewind scan
        logic       rd_en;       // read next entry
        logic       wr_key;      // write key at scanned slot, keep old entry
        logic       wr_carry;    // write kept entry at scanned slot
        logic       wr_down;     // move scanned entry one slot down
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;    // capture result payload
        logic       res_success;
        logic [1:0] res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       dvld;   // read data of last cycle is present
        logic       din;    // that entry lies below the key count
        logic       ge;     // entry not below the key
        logic       eq;     // entry equals the key
        logic       full;
        logic [1:0] op;
    } t_sts;

endpackage

// ===== design/sset_if.sv =====
// request and response channel interfaces of the sorted key set
// depends on sset_pkg for field widths
interface sset_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          op;
    logic signed [sset_pkg::KEY_W-1:0]   key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface sset_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         success;
    logic [1:0]                   status;
    logic [sset_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output success, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input success, input status, input occupancy,
                    output ready);
endinterface

// ===== design/sset_dp.sv =====
// datapath: key memory, scan pointers, carry register, count and result payload
// depends on sset_pkg
module sset_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [1:0]                         i_op,
    input  logic signed [sset_pkg::KEY_W-1:0]  i_key,
    input  sset_pkg::t_cmd                     i_cmd,
    output sset_pkg::t_sts                     o_sts,
    output logic                               o_success,
    output logic [1:0]                         o_status,
    output logic [sset_pkg::OCC_W-1:0]         o_occupancy
);
    import sset_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 2);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [KEY_W-1:0]        mem [CAPACITY];
    logic [1:0]              r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_pidx;
    logic                    r_ptk;
    logic                    r_pin;
    logic [KEY_W-1:0]        r_rd_data;
    logic [KEY_W-1:0]        r_carry;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_success;
    logic [1:0]              r_status;
    logic [OCC_W-1:0]        r_occ;
    logic [CW+OCC_W-1:0]     occ_wide;
    logic                    wr_en;
    logic [CW-1:0]           wr_ptr;
    logic [KEY_W-1:0]        wr_data;

    // request capture and scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptk <= 1'b0;
        end else begin
            r_ptk <= i_cmd.rd_en;
        end
        if (i_cmd.start) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_idx <= '0;
        end else if (i_cmd.rd_en) begin
            r_idx <= r_idx + ONE;
        end
        if (i_cmd.rd_en) begin
            r_pidx <= r_idx;
            r_pin  <= (r_idx < r_count);
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    // memory write port
    always_comb begin
        wr_en   = i_cmd.wr_key | i_cmd.wr_carry | i_cmd.wr_down;
        wr_ptr  = r_pidx;
        wr_data = r_carry;
        if (i_cmd.wr_key) begin
            wr_data = r_key;
        end else if (i_cmd.wr_down) begin
            wr_ptr  = r_pidx - ONE;
            wr_data = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_ptr[AW-1:0]] <= wr_data;
        end
    end

    // entry displaced by an insert travels one slot up
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key || i_cmd.wr_carry) begin
            r_carry <= r_rd_data;
        end
    end

    // key count
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + ONE;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result payload, occupancy is the count kept to its low bits
    assign occ_wide = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_success <= i_cmd.res_success;
            r_status  <= i_cmd.res_status;
            r_occ     <= occ_wide[OCC_W-1:0];
        end
    end

    // status to controller
    always_comb begin
        o_sts.dvld = r_ptk;
        o_sts.din  = r_pin;
        o_sts.ge   = ($signed(r_rd_data) >= r_key);
        o_sts.eq   = (r_rd_data == r_key);
        o_sts.full = (r_count >= CAP);
        o_sts.op   = r_op;
    end

    assign o_success   = r_success;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

endmodule

// ===== design/sset_ctrl.sv =====
// controller: request sequencing, scan/shift control and result handshake
// depends on sset_pkg
module sset_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  sset_pkg::t_sts  i_sts,
    output sset_pkg::t_cmd  o_cmd
);
    import sset_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_INS    = 4'b0100,
        S_DEL    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   found;
    logic   held;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_vld || i_out_ready);
    assign found      = i_sts.dvld && (!i_sts.din || i_sts.ge);
    assign held       = i_sts.din && i_sts.eq;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.rd_en = 1'b1;
                if (found) begin
                    n_state = S_IDLE;
                    case (i_sts.op)
                        OP_INSERT: begin
                            if (held) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_PRESENT;
                            end else if (i_sts.full) begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_FULL;
                            end else begin
                                o_cmd.wr_key = 1'b1;
                                if (i_sts.din) begin
                                    n_state = S_INS;
                                end else begin
                                    o_cmd.cnt_inc     = 1'b1;
                                    o_cmd.res_load    = 1'b1;
                                    o_cmd.res_success = 1'b1;
                                    o_cmd.res_status  = ST_DONE;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (held) begin
                                n_state = S_DEL;
                            end else begin
                                o_cmd.res_load   = 1'b1;
                                o_cmd.res_status = ST_ABSENT;
                            end
                        end
                        default: begin
                            o_cmd.res_load    = 1'b1;
                            o_cmd.res_success = held;
                            o_cmd.res_status  = held ? ST_DONE : ST_ABSENT;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.dvld) begin
                    o_cmd.wr_carry = 1'b1;
                    if (!i_sts.din) begin
                        o_cmd.cnt_inc     = 1'b1;
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_success = 1'b1;
                        o_cmd.res_status  = ST_DONE;
                        n_state           = S_IDLE;
                    end
                end
            end
            S_DEL: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.dvld) begin
                    if (i_sts.din) begin
                        o_cmd.wr_down = 1'b1;
                    end else begin
                        o_cmd.cnt_dec     = 1'b1;
                        o_cmd.res_load    = 1'b1;
                        o_cmd.res_success = 1'b1;
                        o_cmd.res_status  = ST_DONE;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid: cleared on transfer, set when a result is captured
    always_comb begin
        n_out_vld = r_out_vld;
        if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (o_cmd.res_load) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ===== design/sorted_set_member_insert_delete_top.sv =====
// channel    dir   handshake        payload
// i_req      in    valid/ready      op[1:0], key[31:0] signed
// o_rsp      out   valid/ready      success, status[1:0], occupancy[6:0]
//
// one request at a time; the time from the request transfer to the result depends on
// N, the keys held before the request, and is set by the key memory's single
// read port scanning one entry per cycle (search, then the shift of later entries)
// the next request transfers in the cycle after the result is captured at the earliest
// a result waiting in the output register holds off the next request transfer
// reset clears the key count; memory contents are left as they are
// depends on sset_pkg, sset_if, sset_ctrl, sset_dp
module sorted_set_member_insert_delete_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sset_req_if.sink    i_req,
    sset_rsp_if.source  o_rsp
);
    import sset_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    sset_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage and compare
    sset_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_req.op),
        .i_key       (i_req.key),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_success   (o_rsp.success),
        .o_status    (o_rsp.status),
        .o_occupancy (o_rsp.occupancy)
    );

endmodule

// ===== design/sset_chk.sv =====
// port-level checker of the sorted key set, bound to the top level
// depends on sset_pkg and assert_macros.svh
`include "assert_macros.svh"

module sset_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_success,
    input logic [1:0]  i_rsp_status,
    input logic [6:0]  i_rsp_occupancy
);
    import sset_pkg::*;

    // success goes with done status and only with it
    `AM_ASSERT(a_success_done, i_clk, i_rst_n, i_rsp_valid |-> (i_rsp_success == (i_rsp_status == ST_DONE)), "success and status disagree")

    // one request in flight: no transfer right after a transfer
    `AM_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready, "request taken while busy")

    // a waiting result keeps its payload
    `AM_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_success) && $stable(i_rsp_status) && $stable(i_rsp_occupancy)), "result changed while stalled")

    // reset drops any pending result
    `AM_ASSERT_NR(a_reset_clear, i_clk, !i_rst_n |=> !i_rsp_valid, "result valid after reset")

endmodule

bind sorted_set_member_insert_delete_top sset_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_success   (o_rsp.success),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_occupancy (o_rsp.occupancy)
);
